@@ hdl/esl_pkg.sv @@
// esl_pkg: shared types and constants for the expert slice LRU tag store.
// Word layouts, sequencer states, order-list opcodes and control bundles.
// No dependencies.
package esl_pkg;

  localparam int LAYER_FW  = 8;
  localparam int EXPERT_FW = 8;
  localparam int SLOT_W    = 6;
  localparam int OCC_W     = 7;
  localparam int CNT_W     = 32;
  localparam int CAP_W     = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_INVAL  = 1'b1;

  typedef struct packed {
    logic                 action;
    logic [LAYER_FW-1:0]  layer_index;
    logic [EXPERT_FW-1:0] expert_index;
    logic                 fill_ok;
  } in_word_t;

  typedef struct packed {
    logic              hit;
    logic              granted;
    logic [SLOT_W-1:0] slot;
    logic              evicted;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [OCC_W-1:0]  occupancy;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_MOVE,
    ST_PACK,
    ST_RESP
  } seq_state_t;

  typedef enum logic [1:0] {
    LOP_MOVE,
    LOP_TAIL,
    LOP_PACK
  } list_op_t;

  typedef struct packed {
    logic start;
    logic inval;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_sts_t;

  typedef struct packed {
    logic     start;
    list_op_t op;
  } list_ctl_t;

endpackage

@@ hdl/esl_tag_scan.sv @@
// esl_tag_scan: tag memory, per-slot valid bits and the one-entry-per-cycle
// compare unit used for lookup, free-slot search and layer invalidation.
// Depends on esl_pkg.
module esl_tag_scan
  import esl_pkg::*;
#(
  parameter int ENTRIES      = 64,
  parameter int LAYER_WIDTH  = 8,
  parameter int EXPERT_WIDTH = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scan_ctl_t                   ctl,
  input  logic [LAYER_WIDTH-1:0]      layer_tag,
  input  logic [EXPERT_WIDTH-1:0]     expert_tag,
  output scan_sts_t                   sts,
  output logic [$clog2(ENTRIES)-1:0]  hit_slot,
  output logic [$clog2(ENTRIES)-1:0]  free_slot,
  input  logic                        wr_en,
  input  logic [$clog2(ENTRIES)-1:0]  wr_slot,
  input  logic [$clog2(ENTRIES)-1:0]  probe_slot,
  output logic                        probe_valid
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int TAG_W = LAYER_WIDTH + EXPERT_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [TAG_W-1:0]   tag_mem [ENTRIES];
  logic [TAG_W-1:0]   rd_q_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic               busy_r, busy_nxt;
  logic [IDX_W-1:0]   addr_r, addr_nxt;
  logic               chk_r, chk_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic               inval_r, inval_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_slot_r, hit_slot_nxt;
  logic               free_found_r, free_found_nxt;
  logic [IDX_W-1:0]   free_slot_r, free_slot_nxt;
  logic               done_r, done_nxt;
  logic               match;

  always_comb begin
    busy_nxt       = busy_r;
    addr_nxt       = addr_r;
    chk_nxt        = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    inval_nxt      = inval_r;
    hit_nxt        = hit_r;
    hit_slot_nxt   = hit_slot_r;
    free_found_nxt = free_found_r;
    free_slot_nxt  = free_slot_r;
    valid_nxt      = valid_r;
    done_nxt       = 1'b0;

    // layer only for invalidate, full pair for lookup
    match = chk_r && valid_r[chk_idx_r]
            && (rd_q_r[TAG_W-1:EXPERT_WIDTH] == layer_tag)
            && (inval_r || (rd_q_r[EXPERT_WIDTH-1:0] == expert_tag));

    if (ctl.start) begin
      busy_nxt       = 1'b1;
      addr_nxt       = '0;
      inval_nxt      = ctl.inval;
      hit_nxt        = 1'b0;
      free_found_nxt = 1'b0;
    end else if (busy_r) begin
      chk_nxt     = 1'b1;
      chk_idx_nxt = addr_r;
      if (addr_r == LAST_IDX) begin
        busy_nxt = 1'b0;
        addr_nxt = '0;
      end else begin
        addr_nxt = addr_r + 1'b1;
      end
    end

    if (chk_r) begin
      if (match && inval_r) begin
        valid_nxt[chk_idx_r] = 1'b0;
      end
      if (match && !inval_r && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_slot_nxt = chk_idx_r;
      end
      if (!valid_r[chk_idx_r] && !free_found_r) begin
        free_found_nxt = 1'b1;
        free_slot_nxt  = chk_idx_r;
      end
      if (chk_idx_r == LAST_IDX) begin
        done_nxt = 1'b1;
      end
    end

    if (wr_en) begin
      valid_nxt[wr_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      busy_r  <= 1'b0;
      addr_r  <= '0;
      chk_r   <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      busy_r  <= busy_nxt;
      addr_r  <= addr_nxt;
      chk_r   <= chk_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r    <= chk_idx_nxt;
    inval_r      <= inval_nxt;
    hit_r        <= hit_nxt;
    hit_slot_r   <= hit_slot_nxt;
    free_found_r <= free_found_nxt;
    free_slot_r  <= free_slot_nxt;
  end

  // tag memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      tag_mem[wr_slot] <= {layer_tag, expert_tag};
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= tag_mem[addr_r];
  end

  assign sts.done    = done_r;
  assign sts.hit     = hit_r;
  assign hit_slot    = hit_slot_r;
  assign free_slot   = free_slot_r;
  assign probe_valid = valid_r[probe_slot];

endmodule

@@ hdl/esl_order_list.sv @@
// esl_order_list: recency list (slot numbers, most recent first) in a memory,
// with a sweep unit for move-to-front/insert, tail read and compaction.
// Depends on esl_pkg.
module esl_order_list
  import esl_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  list_ctl_t                     ctl,
  input  logic [$clog2(ENTRIES)-1:0]    slot,
  input  logic [$clog2(ENTRIES+1)-1:0]  len,
  output logic                          done,
  output logic [$clog2(ENTRIES)-1:0]    victim,
  output logic [$clog2(ENTRIES+1)-1:0]  new_len,
  output logic [$clog2(ENTRIES)-1:0]    probe_slot,
  input  logic                          probe_valid
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LEN_W = $clog2(ENTRIES + 1);

  logic [IDX_W-1:0] list_mem [ENTRIES];
  logic [IDX_W-1:0] rd_q_r;

  logic             act_r, act_nxt;
  list_op_t         op_r, op_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] ra_r, ra_nxt;
  logic [LEN_W-1:0] pp_r, pp_nxt;
  logic [LEN_W-1:0] wp_r, wp_nxt;
  logic             chk_r, chk_nxt;
  logic [IDX_W-1:0] carry_r, carry_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] victim_r, victim_nxt;
  logic             done_r, done_nxt;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] wr_data;
  logic             finish;

  always_comb begin
    act_nxt    = act_r;
    op_nxt     = op_r;
    len_nxt    = len_r;
    ra_nxt     = ra_r;
    pp_nxt     = pp_r;
    wp_nxt     = wp_r;
    chk_nxt    = 1'b0;
    carry_nxt  = carry_r;
    slot_nxt   = slot_r;
    victim_nxt = victim_r;
    done_nxt   = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = pp_r[IDX_W-1:0];
    wr_data    = carry_r;
    finish     = 1'b0;

    if (ctl.start) begin
      act_nxt   = 1'b1;
      op_nxt    = ctl.op;
      len_nxt   = len;
      pp_nxt    = '0;
      wp_nxt    = '0;
      carry_nxt = slot;
      slot_nxt  = slot;
      ra_nxt    = (ctl.op == LOP_TAIL) ? len - 1'b1 : '0;
    end else if (act_r) begin
      // reads run one position ahead of the write side
      if (ra_r < len_r) begin
        ra_nxt  = ra_r + 1'b1;
        chk_nxt = 1'b1;
      end
      unique case (op_r)
        LOP_MOVE: begin
          if (pp_r == len_r) begin
            // slot was not in the list: the carried entry lands past the old tail
            wr_en  = 1'b1;
            finish = 1'b1;
          end else if (chk_r) begin
            wr_en = 1'b1;
            if (rd_q_r == slot_r) begin
              finish = 1'b1;
            end else begin
              carry_nxt = rd_q_r;
              pp_nxt    = pp_r + 1'b1;
            end
          end
        end
        LOP_TAIL: begin
          if (chk_r) begin
            victim_nxt = rd_q_r;
            finish     = 1'b1;
          end
        end
        LOP_PACK: begin
          if (pp_r == len_r) begin
            finish = 1'b1;
          end else if (chk_r) begin
            if (probe_valid) begin
              wr_en   = 1'b1;
              wr_addr = wp_r[IDX_W-1:0];
              wr_data = rd_q_r;
              wp_nxt  = wp_r + 1'b1;
            end
            pp_nxt = pp_r + 1'b1;
          end
        end
        default: begin
          finish = 1'b1;
        end
      endcase
      if (finish) begin
        act_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      chk_r  <= 1'b0;
      done_r <= 1'b0;
      op_r   <= LOP_MOVE;
    end else begin
      act_r  <= act_nxt;
      chk_r  <= chk_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r    <= len_nxt;
    ra_r     <= ra_nxt;
    pp_r     <= pp_nxt;
    wp_r     <= wp_nxt;
    carry_r  <= carry_nxt;
    slot_r   <= slot_nxt;
    victim_r <= victim_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_q_r <= list_mem[ra_r[IDX_W-1:0]];
  end

  assign done       = done_r;
  assign victim     = victim_r;
  assign new_len    = wp_r;
  assign probe_slot = rd_q_r;

endmodule

@@ hdl/expert_slice_lru_cache.sv @@
// expert_slice_lru_cache: fully associative (layer, expert) tag store, LRU order.
// Top level: request sequencer, counters, capacity register, result register.
// Depends on esl_pkg, esl_tag_scan, esl_order_list.
// Usage:
//   in_*  : request word (access a pair, or invalidate one layer). Taken when
//           in_valid and in_ready are both high; in_ready is high only while
//           the sequencer is idle, one request at a time.
//   out_* : one result word per request, held in an output register until
//           out_ready. A new request is taken while a result still waits;
//           the next result then holds in ST_RESP until the register frees.
//   cfg_* : capacity write, taken on any cycle cfg_we is high (write only
//           while idle). 0 acts as 1, values above ENTRIES act as ENTRIES.
// Sequence of a request: tag scan over all ENTRIES slots, one slot per cycle;
//   then the list sweep, one position per cycle: a hit moves its slot to the front,
//   a fill into a free slot inserts it, an eviction reads the tail and then moves
//   the victim to the front, an invalidate compacts the list, and a miss without fill
//   skips the sweep; then the result. in_ready returns when the result is registered.
// Reset (sync, rst_n low): all slots invalid, counters zero, capacity 64.
// No memory clearing pass; tag and list contents are only read when valid.
module expert_slice_lru_cache
  import esl_pkg::*;
#(
  parameter int ENTRIES      = 64,
  parameter int LAYER_WIDTH  = 8,
  parameter int EXPERT_WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int LEN_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (LEN_W > CAP_W) ? LEN_W : CAP_W;

  seq_state_t        state_r, state_nxt;
  in_word_t          req_r;
  logic [CAP_W-1:0]  cap_r;
  logic [LEN_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_granted_r, res_granted_nxt;
  logic [IDX_W-1:0]  res_slot_r, res_slot_nxt;
  logic              res_evicted_r, res_evicted_nxt;
  logic              grow_r, grow_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_word_t         out_data_r, out_data_nxt;

  logic [CMP_W-1:0]  cap_eff;
  logic              full;

  scan_ctl_t         scan_ctl;
  scan_sts_t         scan_sts;
  logic [IDX_W-1:0]  scan_hit_slot;
  logic [IDX_W-1:0]  scan_free_slot;
  logic              tag_wr_en;
  logic [IDX_W-1:0]  tag_wr_slot;
  logic [IDX_W-1:0]  probe_slot;
  logic              probe_valid;

  list_ctl_t         list_ctl;
  logic [IDX_W-1:0]  list_slot;
  logic              list_done;
  logic [IDX_W-1:0]  list_victim;
  logic [LEN_W-1:0]  list_new_len;

  logic [LAYER_WIDTH-1:0]  layer_tag;
  logic [EXPERT_WIDTH-1:0] expert_tag;

  // tags keep the low LAYER_WIDTH / EXPERT_WIDTH bits of the request fields
  assign layer_tag  = LAYER_WIDTH'(req_r.layer_index);
  assign expert_tag = EXPERT_WIDTH'(req_r.expert_index);

  // clamp capacity into 1 .. ENTRIES
  always_comb begin
    cap_eff = CMP_W'(cap_r);
    if (cap_r == '0) begin
      cap_eff = CMP_W'(1);
    end else if (CMP_W'(cap_r) > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end
  end

  assign full = (CMP_W'(occ_r) >= cap_eff);

  esl_tag_scan #(
    .ENTRIES      (ENTRIES),
    .LAYER_WIDTH  (LAYER_WIDTH),
    .EXPERT_WIDTH (EXPERT_WIDTH)
  ) u_tag_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (scan_ctl),
    .layer_tag   (layer_tag),
    .expert_tag  (expert_tag),
    .sts         (scan_sts),
    .hit_slot    (scan_hit_slot),
    .free_slot   (scan_free_slot),
    .wr_en       (tag_wr_en),
    .wr_slot     (tag_wr_slot),
    .probe_slot  (probe_slot),
    .probe_valid (probe_valid)
  );

  esl_order_list #(
    .ENTRIES (ENTRIES)
  ) u_order_list (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (list_ctl),
    .slot        (list_slot),
    .len         (occ_r),
    .done        (list_done),
    .victim      (list_victim),
    .new_len     (list_new_len),
    .probe_slot  (probe_slot),
    .probe_valid (probe_valid)
  );

  // sequencer: scan, then optional tail read, then list sweep (none on a miss without fill), then result
  always_comb begin
    state_nxt       = state_r;
    occ_nxt         = occ_r;
    hit_cnt_nxt     = hit_cnt_r;
    miss_cnt_nxt    = miss_cnt_r;
    res_hit_nxt     = res_hit_r;
    res_granted_nxt = res_granted_r;
    res_slot_nxt    = res_slot_r;
    res_evicted_nxt = res_evicted_r;
    grow_nxt        = grow_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_data_nxt    = out_data_r;
    scan_ctl.start  = 1'b0;
    scan_ctl.inval  = 1'b0;
    list_ctl.start  = 1'b0;
    list_ctl.op     = LOP_MOVE;
    list_slot       = scan_hit_slot;
    tag_wr_en       = 1'b0;
    tag_wr_slot     = scan_free_slot;
    in_ready        = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          scan_ctl.start  = 1'b1;
          scan_ctl.inval  = (in_data.action == ACT_INVAL);
          res_hit_nxt     = 1'b0;
          res_granted_nxt = 1'b0;
          res_slot_nxt    = '0;
          res_evicted_nxt = 1'b0;
          grow_nxt        = 1'b0;
          state_nxt       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          if (req_r.action == ACT_INVAL) begin
            list_ctl.start = 1'b1;
            list_ctl.op    = LOP_PACK;
            state_nxt      = ST_PACK;
          end else if (scan_sts.hit) begin
            if (hit_cnt_r != {CNT_W{1'b1}}) begin
              hit_cnt_nxt = hit_cnt_r + 1'b1;
            end
            res_hit_nxt     = 1'b1;
            res_granted_nxt = 1'b1;
            res_slot_nxt    = scan_hit_slot;
            list_ctl.start  = 1'b1;
            list_slot       = scan_hit_slot;
            state_nxt       = ST_MOVE;
          end else begin
            if (miss_cnt_r != {CNT_W{1'b1}}) begin
              miss_cnt_nxt = miss_cnt_r + 1'b1;
            end
            if (!req_r.fill_ok) begin
              state_nxt = ST_RESP;
            end else if (full) begin
              // LRU victim is the tail of the recency list
              list_ctl.start = 1'b1;
              list_ctl.op    = LOP_TAIL;
              state_nxt      = ST_TAIL;
            end else begin
              tag_wr_en       = 1'b1;
              tag_wr_slot     = scan_free_slot;
              res_granted_nxt = 1'b1;
              res_slot_nxt    = scan_free_slot;
              grow_nxt        = 1'b1;
              list_ctl.start  = 1'b1;
              list_slot       = scan_free_slot;
              state_nxt       = ST_MOVE;
            end
          end
        end
      end
      ST_TAIL: begin
        if (list_done) begin
          // replace in place: victim moves to the front with the new tag
          tag_wr_en       = 1'b1;
          tag_wr_slot     = list_victim;
          res_granted_nxt = 1'b1;
          res_slot_nxt    = list_victim;
          res_evicted_nxt = 1'b1;
          list_ctl.start  = 1'b1;
          list_slot       = list_victim;
          state_nxt       = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (list_done) begin
          if (grow_r) begin
            occ_nxt = occ_r + 1'b1;
          end
          state_nxt = ST_RESP;
        end
      end
      ST_PACK: begin
        if (list_done) begin
          occ_nxt   = list_new_len;
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.hit        = res_hit_r;
          out_data_nxt.granted    = res_granted_r;
          out_data_nxt.slot       = SLOT_W'(res_slot_r);
          out_data_nxt.evicted    = res_evicted_r;
          out_data_nxt.hit_total  = hit_cnt_r;
          out_data_nxt.miss_total = miss_cnt_r;
          out_data_nxt.occupancy  = OCC_W'(occ_r);
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      occ_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_data;
    end
    res_hit_r     <= res_hit_nxt;
    res_granted_r <= res_granted_nxt;
    res_slot_r    <= res_slot_nxt;
    res_evicted_r <= res_evicted_nxt;
    grow_r        <= grow_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
